// ----- hw/rtl/i2cmbe_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and codes for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

	// operation codes carried by an input request
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	// configuration register indexes
	localparam logic REG_ACK_WAIT_LIMIT = 1'b0;

	localparam logic [9:0] ACK_WAIT_LIMIT_RST = 10'd500;

	// bit-phase sequencer states
	typedef enum logic [4:0] {
		PH_IDLE = 5'd0,
		PH_ST0  = 5'd1,
		PH_ST1  = 5'd2,
		PH_ST2  = 5'd3,
		PH_SP0  = 5'd4,
		PH_SP1  = 5'd5,
		PH_WA   = 5'd6,
		PH_WB   = 5'd7,
		PH_WC   = 5'd8,
		PH_A0   = 5'd9,
		PH_A1   = 5'd10,
		PH_A2   = 5'd11,
		PH_A3   = 5'd12,
		PH_R0   = 5'd13,
		PH_RA   = 5'd14,
		PH_RB   = 5'd15,
		PH_K0   = 5'd16,
		PH_K1   = 5'd17,
		PH_K2   = 5'd18,
		PH_K3   = 5'd19
	} phase_t;

	// one input request (one bit-time tick)
	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] data_byte;
		logic       ack_after_read;
		logic       sda_sample;
	} item_t;

	// one result
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_released;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_received;
		logic       command_rejected;
	} res_t;

endpackage

// ----- hw/rtl/i2cmbe_core.sv -----
// ----------------------------------------------------------------------------
// i2cmbe_core
// Bit-phase sequencer: runs one phase per tick and holds the engine state.
// ----------------------------------------------------------------------------
module i2cmbe_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  i2cmbe_pkg::item_t  item,
	input  logic [9:0]         ack_wait_limit,
	output i2cmbe_pkg::res_t   res
);
	import i2cmbe_pkg::*;

	phase_t     phase_q, phase_d;
	logic [2:0] bit_cnt_q, bit_cnt_d;
	logic [7:0] shift_q, shift_d;
	logic [9:0] wait_cnt_q, wait_cnt_d;
	logic       send_ack_q, send_ack_d;
	logic       scl_q, scl_d;
	logic       sdo_q, sdo_d;
	logic       rel_q, rel_d;
	logic [7:0] last_read_q, last_read_d;
	logic       last_ack_q, last_ack_d;

	logic       is_cmd;
	logic       done;
	logic [7:0] rd_shift;

	// next state for one tick
	always_comb begin
		phase_d     = phase_q;
		bit_cnt_d   = bit_cnt_q;
		shift_d     = shift_q;
		wait_cnt_d  = wait_cnt_q;
		send_ack_d  = send_ack_q;
		scl_d       = scl_q;
		sdo_d       = sdo_q;
		rel_d       = rel_q;
		last_read_d = last_read_q;
		last_ack_d  = last_ack_q;
		done        = 1'b0;
		rd_shift    = {shift_q[6:0], item.sda_sample};
		is_cmd      = (item.operation == OP_START) || (item.operation == OP_STOP) ||
			(item.operation == OP_WRITE) || (item.operation == OP_READ);

		// command launch from idle; the launching tick runs the first phase
		if (phase_q == PH_IDLE && is_cmd) begin
			bit_cnt_d = 3'd0;
			case (item.operation)
				OP_START: phase_d = PH_ST0;
				OP_STOP:  phase_d = PH_SP0;
				OP_WRITE: begin
					shift_d = item.data_byte;
					phase_d = PH_WA;
				end
				default: begin
					send_ack_d = item.ack_after_read;
					phase_d    = PH_R0;
				end
			endcase
		end

		unique case (phase_d)
			PH_ST0: begin
				rel_d = 1'b0; sdo_d = 1'b1; scl_d = 1'b1;
				phase_d = PH_ST1;
			end
			PH_ST1: begin
				sdo_d = 1'b0;
				phase_d = PH_ST2;
			end
			PH_ST2: begin
				scl_d = 1'b0;
				phase_d = PH_IDLE;
				done = 1'b1;
			end
			PH_SP0: begin
				rel_d = 1'b0; sdo_d = 1'b0; scl_d = 1'b1;
				phase_d = PH_SP1;
			end
			PH_SP1: begin
				sdo_d = 1'b1;
				phase_d = PH_IDLE;
				done = 1'b1;
			end
			// write: data bit, clock high, clock low
			PH_WA: begin
				rel_d   = 1'b0;
				sdo_d   = shift_d[7];
				shift_d = {shift_d[6:0], 1'b0};
				phase_d = PH_WB;
			end
			PH_WB: begin
				scl_d = 1'b1;
				phase_d = PH_WC;
			end
			PH_WC: begin
				scl_d = 1'b0;
				if (bit_cnt_d == 3'd7) begin
					bit_cnt_d = 3'd0;
					phase_d   = PH_A0;
				end else begin
					bit_cnt_d = bit_cnt_d + 3'd1;
					phase_d   = PH_WA;
				end
			end
			// acknowledge poll
			PH_A0: begin
				rel_d = 1'b1;
				wait_cnt_d = 10'd0;
				phase_d = PH_A1;
			end
			PH_A1: begin
				scl_d = 1'b1;
				phase_d = PH_A2;
			end
			PH_A2: begin
				if (!item.sda_sample) begin
					last_ack_d = 1'b1;
					phase_d    = PH_A3;
				end else if (wait_cnt_d >= ack_wait_limit) begin
					last_ack_d = 1'b0;
					phase_d    = PH_A3;
				end else begin
					wait_cnt_d = wait_cnt_d + 10'd1;
				end
			end
			PH_A3: begin
				scl_d = 1'b0;
				rel_d = 1'b0;
				if (last_ack_d) begin
					phase_d = PH_IDLE;
					done    = 1'b1;
				end else begin
					phase_d = PH_SP0;
				end
			end
			// read: release, then clock in eight bits
			PH_R0: begin
				rel_d = 1'b1;
				bit_cnt_d = 3'd0;
				shift_d = 8'd0;
				phase_d = PH_RA;
			end
			PH_RA: begin
				scl_d = 1'b1;
				phase_d = PH_RB;
			end
			PH_RB: begin
				shift_d = rd_shift;
				scl_d   = 1'b0;
				if (bit_cnt_d == 3'd7) begin
					bit_cnt_d   = 3'd0;
					last_read_d = rd_shift;
					phase_d     = PH_K0;
				end else begin
					bit_cnt_d = bit_cnt_d + 3'd1;
					phase_d   = PH_RA;
				end
			end
			// master ACK / NACK after read
			PH_K0: begin
				rel_d = 1'b0;
				sdo_d = ~send_ack_d;
				phase_d = PH_K1;
			end
			PH_K1: begin
				scl_d = 1'b1;
				phase_d = PH_K2;
			end
			PH_K2: begin
				scl_d = 1'b0;
				if (send_ack_d) begin
					phase_d = PH_K3;
				end else begin
					phase_d = PH_IDLE;
					done    = 1'b1;
				end
			end
			PH_K3: begin
				sdo_d = 1'b1;
				phase_d = PH_IDLE;
				done = 1'b1;
			end
			default: phase_d = PH_IDLE;
		endcase

		res.scl_level        = scl_d;
		res.sda_level        = sdo_d;
		res.sda_released     = rel_d;
		res.busy_res         = (phase_q != PH_IDLE) || is_cmd;
		res.done_res         = done;
		res.read_data        = last_read_d;
		res.ack_received     = last_ack_d;
		res.command_rejected = (phase_q != PH_IDLE) && is_cmd;
	end

	// state register, advanced once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_cnt_q   <= 3'd0;
			shift_q     <= 8'd0;
			wait_cnt_q  <= 10'd0;
			send_ack_q  <= 1'b0;
			scl_q       <= 1'b1;
			sdo_q       <= 1'b1;
			rel_q       <= 1'b0;
			last_read_q <= 8'd0;
			last_ack_q  <= 1'b0;
		end else if (fire) begin
			phase_q     <= phase_d;
			bit_cnt_q   <= bit_cnt_d;
			shift_q     <= shift_d;
			wait_cnt_q  <= wait_cnt_d;
			send_ack_q  <= send_ack_d;
			scl_q       <= scl_d;
			sdo_q       <= sdo_d;
			rel_q       <= rel_d;
			last_read_q <= last_read_d;
			last_ack_q  <= last_ack_d;
		end
	end

endmodule

// ----- hw/rtl/i2c_master_byte_engine.sv -----
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master byte engine: one bit-phase per request, drives SCL/SDA levels.
//
//   channel | signals                                   | direction
//   in      | in_valid/in_stall + request fields        | into block
//   out     | out_valid/out_stall + result fields       | out of block
//   cfg     | APB psel/penable/pwrite/paddr/pwdata      | register access
//
// One request per cycle unless out stalls; a request passes the input register,
// then the phase sequencer writes the result register. The sequencer state
// updates in the cycle a request moves into the result register.
// Reset: phase idle, SCL and SDA high and driven, ack_wait_limit 500.
// A stall on out holds the result register and backs up into in_stall.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [7:0] data_byte,
	input  logic       ack_after_read,
	input  logic       sda_sample,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_level,
	output logic       sda_level,
	output logic       sda_released,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_data,
	output logic       ack_received,
	output logic       command_rejected,
	// configuration
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);
	import i2cmbe_pkg::*;

	logic       valid_s1;
	item_t      item_s1;
	logic       valid_s2;
	res_t       res_s2;
	res_t       res_c;
	logic       advance;
	logic       fire;
	logic [9:0] ack_wait_limit_q;

	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{operation, data_byte, ack_after_read, sda_sample};
		end
	end

	i2cmbe_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.item           (item_s1),
		.ack_wait_limit (ack_wait_limit_q),
		.res            (res_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid        = valid_s2;
	assign scl_level        = res_s2.scl_level;
	assign sda_level        = res_s2.sda_level;
	assign sda_released     = res_s2.sda_released;
	assign busy_res         = res_s2.busy_res;
	assign done_res         = res_s2.done_res;
	assign read_data        = res_s2.read_data;
	assign ack_received     = res_s2.ack_received;
	assign command_rejected = res_s2.command_rejected;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_wait_limit_q <= ACK_WAIT_LIMIT_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ACK_WAIT_LIMIT) begin
			ack_wait_limit_q <= pwdata[9:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_ACK_WAIT_LIMIT) begin
			prdata = {22'd0, ack_wait_limit_q};
		end
	end

	// low address bits are not used; paddr[2] selects the register
	logic unused_addr;
	assign unused_addr = ^paddr[1:0];

endmodule

// ----- hw/rtl/i2cmbe_checker.sv -----
// ----------------------------------------------------------------------------
// i2cmbe_checker
// Port-level checks for the I2C master byte engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cmbe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       scl_level,
	input logic       sda_level,
	input logic       sda_released,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] read_data,
	input logic       command_rejected
);

	// a stalled result stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a stalled result keeps its pin levels and read byte
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(scl_level) && $stable(sda_level) &&
			$stable(sda_released) && $stable(read_data))
		else $error("result changed while stalled");

	// completion only on a tick that ran a phase
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> busy_res)
		else $error("done without busy");

	// a rejected request means a sequence was running
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command_rejected |-> busy_res)
		else $error("reject without busy");

endmodule

bind i2c_master_byte_engine i2cmbe_checker u_i2cmbe_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.scl_level        (scl_level),
	.sda_level        (sda_level),
	.sda_released     (sda_released),
	.busy_res         (busy_res),
	.done_res         (done_res),
	.read_data        (read_data),
	.command_rejected (command_rejected)
);
